### design/strb_pkg.sv
// Shared constants, codes, types and the row scaling function
// for the scope trace ring buffer. No dependencies.
package strb_pkg;

  localparam int TRACE_WIDTH_DEF  = 256;
  localparam int NUM_CHANNELS_DEF = 3;

  localparam int REQ_W    = 2;
  localparam int COUNT_W  = 8;
  localparam int SAMPLE_W = 16;
  localparam int AGE_W    = 8;
  localparam int CHAN_W   = 2;
  localparam int LEN_W    = 9;
  localparam int ROW_W    = 8;
  localparam int CLAMP_W  = 10;
  localparam int PROD_W   = 18;
  localparam int TICK_W   = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CLAMP_W-1:0] FULL_SCALE = 10'd1023;

  localparam logic [REQ_W-1:0] REQ_FRAME = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] REG_BOTTOM_ROW    = 2'd0;
  localparam logic [1:0] REG_PLOT_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_SEC = 2'd2;
  localparam logic [1:0] REG_SWITCH_INTV   = 2'd3;

  localparam logic [ROW_W-1:0]  BOTTOM_ROW_RST    = 8'd63;
  localparam logic [ROW_W-1:0]  PLOT_HEIGHT_RST   = 8'd55;
  localparam logic [TICK_W-1:0] TICKS_PER_SEC_RST = 16'd1000;
  localparam logic [TICK_W-1:0] SWITCH_INTV_RST   = 16'd5;

  typedef struct packed {
    logic wr;
    logic rd;
  } strb_mem_ctl_t;

  // bottom - prod/1023, saturating at row 0. For prod below 1023*256 the
  // quotient is exactly (prod + (prod >> 10) + 1) >> 10.
  function automatic logic [ROW_W-1:0] scale_row(input logic [PROD_W-1:0] prod,
                                                 input logic [ROW_W-1:0]  bottom);
    logic [PROD_W:0]    sum;
    logic [ROW_W-1:0]   quot;
    sum  = {1'b0, prod} + {11'd0, prod[PROD_W-1:CLAMP_W]} + {{PROD_W{1'b0}}, 1'b1};
    quot = sum[PROD_W-1:CLAMP_W];
    if (quot > bottom) begin
      return '0;
    end
    return bottom - quot;
  endfunction

endpackage

### design/strb_if.sv
// Handshake channel interfaces for the sample/tick/read requests and the
// status results. Depends on strb_pkg for field widths.
interface strb_in_if;
  logic                          valid;
  logic                          ready;
  logic [strb_pkg::REQ_W-1:0]    req_type;
  logic [strb_pkg::COUNT_W-1:0]  byte_count;
  logic [strb_pkg::SAMPLE_W-1:0] sample_ch0;
  logic [strb_pkg::SAMPLE_W-1:0] sample_ch1;
  logic [strb_pkg::SAMPLE_W-1:0] sample_ch2;
  logic [strb_pkg::AGE_W-1:0]    read_age;

  modport source (output valid, req_type, byte_count, sample_ch0, sample_ch1, sample_ch2,
                  read_age, input ready);
  modport sink (input valid, req_type, byte_count, sample_ch0, sample_ch1, sample_ch2,
                read_age, output ready);
endinterface

interface strb_out_if;
  logic                          valid;
  logic                          ready;
  logic [strb_pkg::CHAN_W-1:0]   shown_channel;
  logic                          volts_mode;
  logic [strb_pkg::LEN_W-1:0]    trace_length;
  logic [strb_pkg::ROW_W-1:0]    point_row;
  logic                          point_valid;
  logic [strb_pkg::SAMPLE_W-1:0] shown_value;

  modport source (output valid, shown_channel, volts_mode, trace_length, point_row,
                  point_valid, shown_value, input ready);
  modport sink (input valid, shown_channel, volts_mode, trace_length, point_row,
                point_valid, shown_value, output ready);
endinterface

### design/scope_trace_ring_buffer_top.sv
// Scrolling scope trace store: request channel in, status channel out, APB
// configuration port. Uses strb_pkg, strb_in_if/strb_out_if, strb_trace_mem.
//
// Each request transaction on in_ch yields exactly one status transaction
// on out_ch. A sample frame scales each present channel to a screen row
// and writes it at the write slot, then advances the ring; a tick counts
// milliseconds into seconds and, if the trace is not empty, rotates the
// shown channel each interval; a read returns the shown channel's row at
// an age from the oldest point. Up to the output register, a frame is
// multiplied, then scaled and written back (state WR), then reaches the
// result state; a tick, a read (one registered memory read) or an unused
// request code goes straight to the result state. One request is in work
// at a time: the next is taken the cycle after the result moves into the
// output register. The output register lets a request be taken while the
// previous result still waits; if the receiver stalls, the finished
// result holds in work and no new request is taken until it moves.
// Reset clears the trace (per-line valid bits, no clearing pass), the
// pointers, the counters and the display state, and loads the register
// defaults. Write the registers only while no request is in work.
module scope_trace_ring_buffer_top #(
  parameter int TRACE_WIDTH  = strb_pkg::TRACE_WIDTH_DEF,
  parameter int NUM_CHANNELS = strb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  strb_in_if.sink                           in_ch,
  strb_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [strb_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [strb_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [strb_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import strb_pkg::*;

  localparam int SLOT_W = $clog2(TRACE_WIDTH);
  localparam int FILL_W = $clog2(TRACE_WIDTH + 1);
  localparam int SUM_W  = AGE_W + 1;

  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(TRACE_WIDTH);
  localparam logic [SUM_W-1:0]  RING_LEN  = SUM_W'(TRACE_WIDTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRACE_WIDTH - 1);
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(NUM_CHANNELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR   = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration
  logic [ROW_W-1:0]  bottom_row_r;
  logic [ROW_W-1:0]  plot_height_r;
  logic [TICK_W-1:0] tps_r;
  logic [TICK_W-1:0] intv_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  // block state
  logic [1:0]          state_r, state_nxt;
  logic [SAMPLE_W-1:0] latest_r [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] latest_nxt [NUM_CHANNELS];
  logic [SLOT_W-1:0]   oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]   wslot_r, wslot_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [TICK_W-1:0]   sec_r, sec_nxt;
  logic [CHAN_W-1:0]   chan_r, chan_nxt;
  logic                volts_r, volts_nxt;

  // transaction in work
  logic                               in_acc;
  logic [SAMPLE_W-1:0]                samp [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]            present;
  logic [NUM_CHANNELS-1:0][PROD_W-1:0] prod_r;
  logic [NUM_CHANNELS-1:0]            lane_we_r;
  logic [SLOT_W-1:0]                  wr_slot_r;
  logic                               pt_ok_r;
  logic                               pt_hit;
  logic [SUM_W-1:0]                   age_sum;
  logic [SLOT_W-1:0]                  rd_slot;
  logic [TICK_W-1:0]                  tick_inc;
  logic [TICK_W-1:0]                  sec_inc;
  logic [SAMPLE_W-1:0]                shown_val;
  logic [ROW_W-1:0]                   mem_row;
  strb_mem_ctl_t                      mem_ctl;

  // output register
  logic                out_valid_r;
  logic                out_free;
  logic                out_load;
  logic [CHAN_W-1:0]   out_chan_r;
  logic                out_volts_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [ROW_W-1:0]    out_row_r;
  logic                out_pvalid_r;
  logic [SAMPLE_W-1:0] out_value_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_row_r  <= BOTTOM_ROW_RST;
      plot_height_r <= PLOT_HEIGHT_RST;
      tps_r         <= TICKS_PER_SEC_RST;
      intv_r        <= SWITCH_INTV_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOTTOM_ROW:    bottom_row_r  <= cfg_pwdata[ROW_W-1:0];
        REG_PLOT_HEIGHT:   plot_height_r <= cfg_pwdata[ROW_W-1:0];
        REG_TICKS_PER_SEC: tps_r         <= cfg_pwdata[TICK_W-1:0];
        REG_SWITCH_INTV:   intv_r        <= cfg_pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOTTOM_ROW:    cfg_prdata = CFG_DATA_W'(bottom_row_r);
      REG_PLOT_HEIGHT:   cfg_prdata = CFG_DATA_W'(plot_height_r);
      REG_TICKS_PER_SEC: cfg_prdata = CFG_DATA_W'(tps_r);
      REG_SWITCH_INTV:   cfg_prdata = CFG_DATA_W'(intv_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- requests
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (k == 0) begin
        samp[k] = in_ch.sample_ch0;
      end else if (k == 1) begin
        samp[k] = in_ch.sample_ch1;
      end else begin
        samp[k] = in_ch.sample_ch2;
      end
      present[k] = in_ch.byte_count > COUNT_W'(2 * k + 1);
    end
  end

  // ring position of the requested age, wrapped once
  assign age_sum = SUM_W'(in_ch.read_age) + SUM_W'(oldest_r);
  assign rd_slot = (age_sum >= RING_LEN) ? SLOT_W'(age_sum - RING_LEN) : SLOT_W'(age_sum);
  assign pt_hit  = (in_ch.req_type == REQ_READ) &&
                   (SUM_W'(in_ch.read_age) < SUM_W'(fill_r));

  assign tick_inc = tick_r + 1'b1;
  assign sec_inc  = sec_r + 1'b1;

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      latest_nxt[k] = latest_r[k];
    end
    oldest_nxt = oldest_r;
    wslot_nxt  = wslot_r;
    fill_nxt   = fill_r;
    tick_nxt   = tick_r;
    sec_nxt    = sec_r;
    chan_nxt   = chan_r;
    volts_nxt  = volts_r;
    if (in_acc) begin
      case (in_ch.req_type)
        REQ_FRAME: begin
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (present[k]) begin
              latest_nxt[k] = samp[k];
            end
          end
          // grow until full, then drop the oldest point
          if (fill_r < FILL_MAX) begin
            fill_nxt = fill_r + 1'b1;
          end else begin
            oldest_nxt = (oldest_r == SLOT_LAST) ? '0 : oldest_r + 1'b1;
          end
          wslot_nxt = (wslot_r == SLOT_LAST) ? '0 : wslot_r + 1'b1;
        end
        REQ_TICK: begin
          if (tick_inc >= tps_r) begin
            tick_nxt = '0;
            if (sec_inc >= intv_r) begin
              sec_nxt = '0;
              if (fill_r != '0) begin
                if (chan_r < CHAN_LAST) begin
                  chan_nxt = chan_r + 1'b1;
                end else begin
                  chan_nxt  = '0;
                  volts_nxt = ~volts_r;
                end
              end
            end else begin
              sec_nxt = sec_inc;
            end
          end else begin
            tick_nxt = tick_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        latest_r[k] <= '0;
      end
      oldest_r <= '0;
      wslot_r  <= '0;
      fill_r   <= '0;
      tick_r   <= '0;
      sec_r    <= '0;
      chan_r   <= '0;
      volts_r  <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        latest_r[k] <= latest_nxt[k];
      end
      oldest_r <= oldest_nxt;
      wslot_r  <= wslot_nxt;
      fill_r   <= fill_nxt;
      tick_r   <= tick_nxt;
      sec_r    <= sec_nxt;
      chan_r   <= chan_nxt;
      volts_r  <= volts_nxt;
    end
  end

  // clamp and multiply now, scale and write back next cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        prod_r[k] <= PROD_W'((samp[k] > SAMPLE_W'(FULL_SCALE)) ? FULL_SCALE
                                                               : samp[k][CLAMP_W-1:0])
                     * PROD_W'(plot_height_r);
      end
      lane_we_r <= present;
      wr_slot_r <= wslot_r;
      pt_ok_r   <= pt_hit;
    end
  end

  assign mem_ctl.wr = (state_r == ST_WR);
  assign mem_ctl.rd = in_acc && (in_ch.req_type == REQ_READ);

  strb_trace_mem #(
    .TRACE_WIDTH  (TRACE_WIDTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .wr_slot    (wr_slot_r),
    .lane_we    (lane_we_r),
    .prod       (prod_r),
    .bottom_row (bottom_row_r),
    .rd_slot    (rd_slot),
    .rd_lane    (chan_r),
    .rd_row     (mem_row)
  );

  // ------------------------------------------------------------ sequencer
  assign out_free = ~out_valid_r | out_ch.ready;
  assign out_load = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.req_type == REQ_FRAME) ? ST_WR : ST_DONE;
        end
      end
      ST_WR:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------- output
  always_comb begin
    shown_val = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (chan_r == CHAN_W'(k)) begin
        shown_val = latest_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r   <= chan_r;
      out_volts_r  <= volts_r;
      out_len_r    <= LEN_W'(fill_r);
      out_row_r    <= pt_ok_r ? mem_row : '0;
      out_pvalid_r <= pt_ok_r;
      out_value_r  <= shown_val;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.shown_channel = out_chan_r;
  assign out_ch.volts_mode    = out_volts_r;
  assign out_ch.trace_length  = out_len_r;
  assign out_ch.point_row     = out_row_r;
  assign out_ch.point_valid   = out_pvalid_r;
  assign out_ch.shown_value   = out_value_r;

  // ----------------------------------------------------------- assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("trace fill count beyond ring size");

  a_growing_ring: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != FILL_MAX |-> (oldest_r == '0) && (wslot_r == SLOT_W'(fill_r)))
    else $error("pointers out of step while the trace grows");

  a_full_ring: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == FILL_MAX |-> wslot_r == oldest_r)
    else $error("write slot does not follow the oldest point on a full ring");

  a_wr_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |=> state_r == ST_DONE)
    else $error("row write-back not followed by result");

  a_point_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pvalid_r |-> out_len_r != '0)
    else $error("valid trace point reported from an empty trace");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r <= CHAN_LAST)
    else $error("shown channel beyond channel count");

endmodule

### design/strb_trace_mem.sv
// Trace row memory: one line per ring slot with a byte lane per channel,
// row scaling on write, per-line valid bits, registered read. Uses strb_pkg.
module strb_trace_mem #(
  parameter int TRACE_WIDTH  = strb_pkg::TRACE_WIDTH_DEF,
  parameter int NUM_CHANNELS = strb_pkg::NUM_CHANNELS_DEF,
  localparam int SLOT_W = $clog2(TRACE_WIDTH)
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  strb_pkg::strb_mem_ctl_t                          ctl,
  input  logic [SLOT_W-1:0]                                wr_slot,
  input  logic [NUM_CHANNELS-1:0]                          lane_we,
  input  logic [NUM_CHANNELS-1:0][strb_pkg::PROD_W-1:0]    prod,
  input  logic [strb_pkg::ROW_W-1:0]                       bottom_row,
  input  logic [SLOT_W-1:0]                                rd_slot,
  input  logic [strb_pkg::CHAN_W-1:0]                      rd_lane,
  output logic [strb_pkg::ROW_W-1:0]                       rd_row
);
  import strb_pkg::*;

  localparam int LINE_W = NUM_CHANNELS * ROW_W;

  logic [LINE_W-1:0]       mem [TRACE_WIDTH];
  logic [TRACE_WIDTH-1:0]  line_vld_r;
  logic [LINE_W-1:0]       wdata;
  logic [NUM_CHANNELS-1:0] wr_lane;
  logic [LINE_W-1:0]       rdata_r;
  logic                    rd_ok_r;
  logic [ROW_W-1:0]        lane_row;

  // A line not yet written holds zero: fill the absent lanes with zero on
  // its first write.
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      wr_lane[k]                 = lane_we[k] | ~line_vld_r[wr_slot];
      wdata[k*ROW_W +: ROW_W]    = lane_we[k] ? scale_row(prod[k], bottom_row) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (wr_lane[k]) begin
          mem[wr_slot][k*ROW_W +: ROW_W] <= wdata[k*ROW_W +: ROW_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[rd_slot];
      rd_ok_r <= line_vld_r[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= '0;
    end else if (ctl.wr) begin
      line_vld_r[wr_slot] <= 1'b1;
    end
  end

  always_comb begin
    lane_row = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (rd_lane == CHAN_W'(k)) begin
        lane_row = rdata_r[k*ROW_W +: ROW_W];
      end
    end
  end

  assign rd_row = rd_ok_r ? lane_row : '0;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the scope trace ring buffer top: drives request transactions,
// predicts every status transaction, programs the APB registers between phases.
// Depends on strb_pkg, strb_in_if/strb_out_if and scope_trace_ring_buffer_top.
module tb;
  import strb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int               LIMIT_CYCLES = 300000;
  localparam int               NUM_PHASES   = 6;
  localparam int               PHASE_ITEMS  = 235;

  typedef struct packed {
    logic [REQ_W-1:0]             req_type;
    logic [COUNT_W-1:0]           byte_count;
    logic [2:0][SAMPLE_W-1:0]     sample;
    logic [AGE_W-1:0]             read_age;
  } scope_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic                volts;
    logic [LEN_W-1:0]    length;
    logic [ROW_W-1:0]    row;
    logic                pvalid;
    logic [SAMPLE_W-1:0] value;
  } scope_status_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  strb_in_if  in_bus ();
  strb_out_if out_bus ();

  scope_trace_ring_buffer_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state and register copies
  logic [ROW_W-1:0]    trace_img [NUM_CHANNELS_DEF][TRACE_WIDTH_DEF];
  logic [SAMPLE_W-1:0] last_raw [NUM_CHANNELS_DEF];
  int unsigned         oldest_ptr, write_ptr, fill_pts, shown_ch;
  logic [TICK_W-1:0]   ms_count, sec_count;
  logic                volts_on;
  logic [ROW_W-1:0]    bottom_cfg, height_cfg;
  logic [TICK_W-1:0]   tps_cfg, interval_cfg;

  scope_req_t    pending_reqs [$];
  scope_status_t status_due [$];
  scope_req_t    held_req;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int cycles;
  int checked;
  int rotations;
  int max_fill;
  int settings_applied;
  int n_by_type [4];

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic scope_status_t predict_status(input scope_req_t r);
    scope_status_t s;
    int unsigned   clamped;
    int unsigned   scaled;
    s = '0;
    n_by_type[r.req_type]++;
    case (r.req_type)
      REQ_FRAME: begin
        for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
          if (r.byte_count > 2 * k + 1) begin
            last_raw[k] = r.sample[k];
            clamped = (r.sample[k] > FULL_SCALE) ? FULL_SCALE : r.sample[k];
            scaled  = clamped * height_cfg / FULL_SCALE;
            trace_img[k][write_ptr] = (scaled > bottom_cfg) ? '0 : ROW_W'(bottom_cfg - scaled);
          end
        end
        // grow until full, then drop the oldest point
        if (fill_pts < TRACE_WIDTH_DEF) begin
          fill_pts++;
        end else begin
          oldest_ptr = (oldest_ptr + 1) % TRACE_WIDTH_DEF;
        end
        write_ptr = (write_ptr + 1) % TRACE_WIDTH_DEF;
        if (fill_pts > max_fill) max_fill = fill_pts;
      end
      REQ_TICK: begin
        ms_count = ms_count + 1'b1;
        if (ms_count >= tps_cfg) begin
          sec_count = sec_count + 1'b1;
          ms_count  = '0;
          if (sec_count >= interval_cfg) begin
            sec_count = '0;
            // an empty trace keeps the shown channel
            if (fill_pts > 0) begin
              rotations++;
              if (shown_ch + 1 < NUM_CHANNELS_DEF) begin
                shown_ch++;
              end else begin
                shown_ch = 0;
                volts_on = ~volts_on;
              end
            end
          end
        end
      end
      REQ_READ: begin
        if (r.read_age < fill_pts) begin
          s.row    = trace_img[shown_ch][(r.read_age + oldest_ptr) % TRACE_WIDTH_DEF];
          s.pvalid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    s.chan   = CHAN_W'(shown_ch);
    s.volts  = volts_on;
    s.length = LEN_W'(fill_pts);
    s.value  = last_raw[shown_ch];
    return s;
  endfunction

  function automatic scope_req_t make_req(input logic [REQ_W-1:0] kind,
                                          input logic [COUNT_W-1:0] count,
                                          input logic [SAMPLE_W-1:0] v0,
                                          input logic [SAMPLE_W-1:0] v1,
                                          input logic [SAMPLE_W-1:0] v2,
                                          input logic [AGE_W-1:0] age);
    scope_req_t r;
    r.req_type   = kind;
    r.byte_count = count;
    r.sample[0]  = v0;
    r.sample[1]  = v1;
    r.sample[2]  = v2;
    r.read_age   = age;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'd1023;
      2:       return 16'd1024;
      3:       return 16'hFFFF;
      4, 5:    return SAMPLE_W'($urandom_range(1023));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic scope_req_t random_req();
    scope_req_t r;
    int         pick;
    int         cpick;
    pick  = $urandom_range(99);
    cpick = $urandom_range(99);
    r = make_req(REQ_FRAME, '0, pick_sample(), pick_sample(), pick_sample(),
                 AGE_W'($urandom_range(255)));
    if (pick < 40) begin
      // mostly full frames; short and arbitrary lengths now and then
      if (cpick < 60) r.byte_count = COUNT_W'($urandom_range(255, 6));
      else if (cpick < 85) r.byte_count = COUNT_W'($urandom_range(5));
      else r.byte_count = COUNT_W'($urandom);
    end else if (pick < 70) begin
      r.req_type   = REQ_TICK;
      r.byte_count = COUNT_W'($urandom);
    end else if (pick < 95) begin
      r.req_type   = REQ_READ;
      r.byte_count = COUNT_W'($urandom);
      if (cpick < 30) r.read_age = AGE_W'($urandom_range(15));
      else if (cpick < 35) r.read_age = '1;
    end else begin
      r.req_type   = REQ_UNUSED;
      r.byte_count = COUNT_W'($urandom);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_BOTTOM_ROW:    bottom_cfg   = val[ROW_W-1:0];
      REG_PLOT_HEIGHT:   height_cfg   = val[ROW_W-1:0];
      REG_TICKS_PER_SEC: tps_cfg      = val[TICK_W-1:0];
      REG_SWITCH_INTV:   interval_cfg = val[TICK_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input logic [ROW_W-1:0] bottom, input logic [ROW_W-1:0] height,
                               input logic [TICK_W-1:0] tps, input logic [TICK_W-1:0] intv);
    write_reg(REG_BOTTOM_ROW, CFG_DATA_W'(bottom));
    write_reg(REG_PLOT_HEIGHT, CFG_DATA_W'(height));
    write_reg(REG_TICKS_PER_SEC, CFG_DATA_W'(tps));
    write_reg(REG_SWITCH_INTV, CFG_DATA_W'(intv));
    settings_applied++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_bus.valid) @(posedge clk);
    while (status_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    logic fire;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      fire = in_bus.valid && in_bus.ready;
      if (fire) status_due.push_back(predict_status(held_req));
      if (!in_bus.valid || fire) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.req_type   <= held_req.req_type;
          in_bus.byte_count <= held_req.byte_count;
          in_bus.sample_ch0 <= held_req.sample[0];
          in_bus.sample_ch1 <= held_req.sample[1];
          in_bus.sample_ch2 <= held_req.sample[2];
          in_bus.read_age   <= held_req.read_age;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor
  always @(posedge clk) begin
    scope_status_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: status transaction with nothing expected, expected none actual %h",
                 $time, {out_bus.shown_channel, out_bus.volts_mode, out_bus.trace_length,
                         out_bus.point_row, out_bus.point_valid, out_bus.shown_value});
      end else begin
        want = status_due.pop_front();
        checked++;
        check_field("shown_channel", want.chan, out_bus.shown_channel);
        check_field("volts_mode", want.volts, out_bus.volts_mode);
        check_field("trace_length", want.length, out_bus.trace_length);
        check_field("point_row", want.row, out_bus.point_row);
        check_field("point_valid", want.pvalid, out_bus.point_valid);
        check_field("shown_value", want.value, out_bus.shown_value);
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.req_type   = '0;
    in_bus.byte_count = '0;
    in_bus.sample_ch0 = '0;
    in_bus.sample_ch1 = '0;
    in_bus.sample_ch2 = '0;
    in_bus.read_age   = '0;
    out_bus.ready     = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    errors            = 0;
    cycles            = 0;
    checked           = 0;
    rotations         = 0;
    max_fill          = 0;
    settings_applied  = 0;
    n_by_type         = '{default: 0};
    for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
      last_raw[k] = '0;
      for (int j = 0; j < TRACE_WIDTH_DEF; j++) trace_img[k][j] = '0;
    end
    oldest_ptr   = 0;
    write_ptr    = 0;
    fill_pts     = 0;
    shown_ch     = 0;
    ms_count     = '0;
    sec_count    = '0;
    volts_on     = 1'b0;
    bottom_cfg   = BOTTOM_ROW_RST;
    height_cfg   = PLOT_HEIGHT_RST;
    tps_cfg      = TICKS_PER_SEC_RST;
    interval_cfg = SWITCH_INTV_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every tick completes an interval
    apply_setting(BOTTOM_ROW_RST, PLOT_HEIGHT_RST, 16'd1, 16'd1);
    // ticks, a read and an unused code on the empty trace
    pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(REQ_TICK, '1, '1, '1, '1, '1));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(REQ_UNUSED, '1, '1, '1, '1, '1));
    // frames short of bytes, then growing channel counts and clamp edges
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd0, 16'd100, 16'd200, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd1, 16'd100, 16'd200, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd2, 16'd0, 16'd200, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd3, 16'd1023, 16'd200, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd4, 16'd1024, 16'd1023, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd5, 16'd512, 16'hFFFF, 16'd300, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd6, 16'hFFFF, 16'd0, 16'd1023, '0));
    pending_reqs.push_back(make_req(REQ_FRAME, 8'd255, 16'd1024, 16'd1, 16'hFFFF, '0));
    // reads inside, at and beyond the trace length
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd0));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd3));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd7));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd8));
    pending_reqs.push_back(make_req(REQ_READ, '1, '1, '1, '1, 8'd255));
    // rotate through every channel and wrap, toggling volts mode
    repeat (4) pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd1));
    pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0, '0, 8'd7));
    pending_reqs.push_back(make_req(REQ_UNUSED, COUNT_W'($urandom), pick_sample(),
                                    pick_sample(), pick_sample(), AGE_W'($urandom)));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(8'd63, 8'd55, 16'd3, 16'd2);
        1: apply_setting(8'd255, 8'd255, 16'd0, 16'd0);
        2: apply_setting(8'd0, 8'd255, 16'd1, 16'hFFFF);
        3: apply_setting(ROW_W'($urandom_range(255)), ROW_W'($urandom_range(255)),
                         16'hFFFF, 16'd1);
        4: apply_setting(8'd200, 8'd100, 16'd2, 16'd1);
        default: apply_setting(8'd30, 8'd0, 16'd1, 16'd3);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // hold the sender mid-phase until every status has come back
      repeat (PHASE_ITEMS / 2) pending_reqs.push_back(random_req());
      wait_drained();
      repeat (PHASE_ITEMS - PHASE_ITEMS / 2) pending_reqs.push_back(random_req());
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (status_due.size() != 0) begin
      errors++;
      $display("%0t: statuses outstanding, expected 0 actual %0d", $time, status_due.size());
    end
    $display("Run: %0d frames, %0d ticks, %0d reads, %0d unused codes; %0d statuses checked",
             n_by_type[REQ_FRAME], n_by_type[REQ_TICK], n_by_type[REQ_READ],
             n_by_type[REQ_UNUSED], checked);
    $display("Run: %0d register settings, %0d channel rotations, trace filled to %0d",
             settings_applied, rotations, max_fill);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
